FILE: rtl/lfu_pkg.sv
// Shared types and constants for the LFU cache table.
// Used by lfu_cell and lfu_cache_table; depends on nothing else.
package lfu_pkg;

  localparam int KEY_W   = 32;
  localparam int COUNT_W = 16;
  localparam int SLOT_W  = 3;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // One stored entry: key, payload and use count
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic signed [31:0]      value;
    logic signed [31:0]      size;
    logic signed [31:0]      tag;
    logic [COUNT_W-1:0]      count;
  } entry_t;

  // Running minimum handed along the row; one extra bit so the head can start above any count
  typedef struct packed {
    logic [COUNT_W:0]        cnt;
    logic signed [KEY_W-1:0] key;
  } scan_t;

  // Per-cell update, chosen in the lookup or commit state
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_BUMP,
    OP_LOAD,
    OP_SHIFT
  } cell_op_t;

endpackage

FILE: rtl/lfu_cell.sv
// One slot of the LFU table: stores an entry, compares its key, passes the running minimum on.
// Depends on lfu_pkg.
module lfu_cell #(
  parameter int POS_W = 3,
  parameter logic [POS_W-1:0] INDEX = '0
) (
  input  logic                    clk,
  input  lfu_pkg::cell_op_t       op,
  input  lfu_pkg::entry_t         req,
  input  lfu_pkg::entry_t         nbr,
  input  logic signed [31:0]      look_key,
  input  lfu_pkg::scan_t          scan_in,
  input  logic [POS_W-1:0]        scan_pos_in,
  output lfu_pkg::entry_t         entry,
  output logic                    match,
  output lfu_pkg::scan_t          scan_out,
  output logic [POS_W-1:0]        scan_pos_out
);
  import lfu_pkg::*;

  logic            take_own;
  logic [COUNT_W:0] own_cnt;

  // Compare against the broadcast key
  assign match = (entry.key == look_key);

  // Update the stored entry
  always_ff @(posedge clk) begin
    unique case (op)
      OP_HOLD: begin
      end
      OP_BUMP: begin
        if (entry.count != COUNT_MAX) begin
          entry.count <= entry.count + COUNT_W'(1);
        end
      end
      OP_LOAD: begin
        entry       <= req;
        entry.count <= COUNT_W'(1);
      end
      OP_SHIFT: begin
        entry <= nbr;
      end
      default: begin
      end
    endcase
  end

  // Keep the earlier candidate on a tie
  assign own_cnt  = {1'b0, entry.count};
  assign take_own = (own_cnt < scan_in.cnt);

  // Advance the running minimum one cell per cycle
  always_ff @(posedge clk) begin
    if (take_own) begin
      scan_out.cnt <= own_cnt;
      scan_out.key <= entry.key;
      scan_pos_out <= INDEX;
    end else begin
      scan_out     <= scan_in;
      scan_pos_out <= scan_pos_in;
    end
  end

endmodule

FILE: rtl/lfu_cache_table.sv
// LFU cache table: row of ENTRIES cells with lookup control and a registered result.
// On a hit or a fill of a free slot the result is registered from the lookup state;
//   on an eviction, from the commit state once the minimum scan has walked the cell row.
// A new request is taken only in the idle state, after the last result is registered;
//   a result held by the sink stalls the next request's update until it is taken.
// Reset (rst, synchronous) empties the table and drops any pending result; no clearing pass.
// Depends on lfu_pkg and lfu_cell.
module lfu_cache_table #(
  parameter int ENTRIES = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // s_tdata from bit 0: req_key[31:0], req_value[63:32], req_size[95:64], req_tag[127:96]
  input  logic [127:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // m_tdata from bit 0: hit[0], slot[3:1], use_count[19:4], evicted[20],
  // evicted_key[52:21], zero fill [55:53]
  output logic [55:0]  m_tdata
);
  import lfu_pkg::*;

  localparam int POS_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_SCAN,
    S_COMMIT
  } state_t;

  state_t             state;
  entry_t             req;
  logic [OCC_W-1:0]   occupancy;
  logic [OCC_W-1:0]   scan_left;

  logic               out_hit;
  logic [SLOT_W-1:0]  out_slot;
  logic [COUNT_W-1:0] out_count;
  logic               out_evicted;
  logic signed [31:0] out_evicted_key;

  entry_t             entry_q  [ENTRIES];
  logic               match_q  [ENTRIES];
  scan_t              scan_q   [ENTRIES];
  logic [POS_W-1:0]   scan_pos [ENTRIES];
  cell_op_t           cell_op  [ENTRIES];

  scan_t              scan_head;
  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES-1:0] first_hit;
  logic               any_hit;
  logic [POS_W-1:0]   hit_pos;
  logic [COUNT_W-1:0] hit_count;
  logic [COUNT_W-1:0] bump_count;
  logic               full;
  logic               out_free;
  logic               out_load;
  logic [POS_W-1:0]   victim;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign full     = (occupancy == OCC_W'(ENTRIES));
  assign victim   = scan_pos[ENTRIES-1];

  // A new result is registered this cycle
  assign out_load = out_free &&
                    ((state == S_LOOKUP && (any_hit || !full)) || state == S_COMMIT);

  assign scan_head.cnt = {1'b1, {COUNT_W{1'b0}}};
  assign scan_head.key = '0;

  // Row of cells; on eviction those from the victim on shift from their right neighbor
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lfu_cell #(
      .POS_W (POS_W),
      .INDEX (POS_W'(i))
    ) u_cell (
      .clk          (clk),
      .op           (cell_op[i]),
      .req          (req),
      .nbr          ((i == ENTRIES - 1) ? req : entry_q[(i == ENTRIES - 1) ? i : i + 1]),
      .look_key     (req.key),
      .scan_in      ((i == 0) ? scan_head : scan_q[(i == 0) ? 0 : i - 1]),
      .scan_pos_in  ((i == 0) ? '0 : scan_pos[(i == 0) ? 0 : i - 1]),
      .entry        (entry_q[i]),
      .match        (match_q[i]),
      .scan_out     (scan_q[i]),
      .scan_pos_out (scan_pos[i])
    );
  end

  // Find the first valid slot holding the key
  always_comb begin
    hit_vec   = '0;
    first_hit = '0;
    hit_pos   = '0;
    hit_count = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = match_q[i] && (OCC_W'(i) < occupancy);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_pos = POS_W'(i);
      end
    end
    for (int i = 0; i < ENTRIES; i++) begin
      first_hit[i] = hit_vec[i] && (hit_pos == POS_W'(i));
      if (first_hit[i]) begin
        hit_count = hit_count | entry_q[i].count;
      end
    end
  end

  assign any_hit    = |hit_vec;
  assign bump_count = (hit_count == COUNT_MAX) ? hit_count : hit_count + COUNT_W'(1);

  // Choose each cell's update for this cycle
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      cell_op[i] = OP_HOLD;
      if (state == S_LOOKUP && out_free) begin
        if (any_hit) begin
          if (first_hit[i]) begin
            cell_op[i] = OP_BUMP;
          end
        end else if (!full && occupancy == OCC_W'(i)) begin
          cell_op[i] = OP_LOAD;
        end
      end else if (state == S_COMMIT && out_free) begin
        if (i == ENTRIES - 1) begin
          cell_op[i] = OP_LOAD;
        end else if (POS_W'(i) >= victim) begin
          cell_op[i] = OP_SHIFT;
        end
      end
    end
  end

  // Hold the request
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req.key   <= s_tdata[31:0];
      req.value <= s_tdata[63:32];
      req.size  <= s_tdata[95:64];
      req.tag   <= s_tdata[127:96];
      req.count <= COUNT_W'(1);
    end
  end

  // Sequence the request and register the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occupancy <= '0;
      scan_left <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (!any_hit && full) begin
            scan_left <= OCC_W'(ENTRIES);
            state     <= S_SCAN;
          end else if (out_free) begin
            m_tvalid        <= 1'b1;
            out_hit         <= any_hit;
            out_evicted     <= 1'b0;
            out_evicted_key <= '0;
            if (any_hit) begin
              out_slot  <= SLOT_W'(hit_pos);
              out_count <= bump_count;
            end else begin
              out_slot  <= SLOT_W'(occupancy);
              out_count <= COUNT_W'(1);
              occupancy <= occupancy + OCC_W'(1);
            end
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (scan_left == '0) begin
            state <= S_COMMIT;
          end else begin
            scan_left <= scan_left - OCC_W'(1);
          end
        end
        S_COMMIT: begin
          if (out_free) begin
            m_tvalid        <= 1'b1;
            out_hit         <= 1'b0;
            out_slot        <= SLOT_W'(ENTRIES - 1);
            out_count       <= COUNT_W'(1);
            out_evicted     <= 1'b1;
            out_evicted_key <= scan_q[ENTRIES-1].key;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {3'b000, out_evicted_key, out_evicted, out_count, out_slot, out_hit};

endmodule

FILE: test/lfu_cache_table_test.sv
// Testbench for lfu_cache_table: streams lookup requests into the table and predicts
// each response with an LFU table kept in the bench; every response field is checked in order.
// Depends on lfu_pkg and the lfu_cache_table RTL.
module lfu_cache_table_test;
  import lfu_pkg::*;

  localparam int ENTRIES      = 8;
  localparam int MAX_GAP      = 6;
  localparam int TAIL_CYCLES  = ENTRIES + 3 + 2 * MAX_GAP;
  localparam int RANDOM_ITEMS = 635;
  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

  // Request word, laid out as on s_tdata (key in the lowest bits)
  typedef struct packed {
    logic signed [31:0]      tag;
    logic signed [31:0]      size;
    logic signed [31:0]      value;
    logic signed [KEY_W-1:0] key;
  } lookup_req_t;

  typedef struct {
    lookup_req_t fields;
    bit          drain;  // hold until every earlier request has answered
    bit          quick;  // no idling on either side for this request
  } pending_lookup_t;

  // Response word, laid out as on m_tdata[52:0] (hit in bit 0)
  typedef struct packed {
    logic signed [KEY_W-1:0] evicted_key;
    logic                    evicted;
    logic [COUNT_W-1:0]      use_count;
    logic [SLOT_W-1:0]       slot;
    logic                    hit;
  } lookup_resp_t;

  typedef struct {
    lookup_resp_t resp;
    bit           quick;
  } expected_lookup_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [55:0]  m_tdata;

  // Bench copy of the table
  entry_t lfu_rows [ENTRIES];
  int     rows_used = 0;

  pending_lookup_t  lookup_queue [$];
  expected_lookup_t expected_lookups [$];
  int unsigned      error_count = 0;

  lfu_cache_table #(.ENTRIES(ENTRIES)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  // Look up one key in the bench table, update it and return the response it causes
  function automatic lookup_resp_t lookup_and_update(lookup_req_t rq);
    lookup_resp_t r;
    int found;
    int victim;
    int i;
    r = '0;
    found = -1;
    for (i = 0; i < rows_used; i++) begin
      if (found < 0 && lfu_rows[i].key == rq.key) found = i;
    end
    if (found >= 0) begin
      // bump the first match, saturating; payload stays as stored
      if (lfu_rows[found].count != COUNT_MAX) lfu_rows[found].count++;
      r.hit       = 1'b1;
      r.slot      = SLOT_W'(found);
      r.use_count = lfu_rows[found].count;
    end else begin
      if (rows_used == ENTRIES) begin
        // evict the lowest count, first one on a tie, and close the gap
        victim = 0;
        for (i = 1; i < ENTRIES; i++) begin
          if (lfu_rows[i].count < lfu_rows[victim].count) victim = i;
        end
        r.evicted     = 1'b1;
        r.evicted_key = lfu_rows[victim].key;
        for (i = victim; i < ENTRIES - 1; i++) begin
          lfu_rows[i] = lfu_rows[i + 1];
        end
        rows_used--;
      end
      lfu_rows[rows_used].key   = rq.key;
      lfu_rows[rows_used].value = rq.value;
      lfu_rows[rows_used].size  = rq.size;
      lfu_rows[rows_used].tag   = rq.tag;
      lfu_rows[rows_used].count = COUNT_W'(1);
      r.slot      = SLOT_W'(rows_used);
      r.use_count = COUNT_W'(1);
      rows_used++;
    end
    return r;
  endfunction

  task automatic queue_lookup(input logic signed [31:0] key, input logic signed [31:0] value,
                              input logic signed [31:0] size, input logic signed [31:0] tag,
                              input bit drain, input bit quick);
    pending_lookup_t item;
    item.fields.key   = key;
    item.fields.value = value;
    item.fields.size  = size;
    item.fields.tag   = tag;
    item.drain        = drain;
    item.quick        = quick;
    lookup_queue.push_back(item);
  endtask

  // Request driver
  int              tx_gap;
  int unsigned     sent_count;
  int unsigned     back_count;
  pending_lookup_t tx_cur;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap = 0;
      sent_count = 0;
      back_count = 0;
    end else begin
      if (m_tvalid && m_tready) back_count++;
      // predict on every accepted request
      if (s_tvalid && s_tready) begin
        expected_lookups.push_back('{resp: lookup_and_update(tx_cur.fields),
                                     quick: tx_cur.quick});
        sent_count++;
      end
      // advance once the bus is free
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (lookup_queue.size() > 0 &&
                     (!lookup_queue[0].drain || sent_count == back_count)) begin
          tx_cur = lookup_queue.pop_front();
          s_tdata  <= tx_cur.fields;
          s_tvalid <= 1'b1;
          tx_gap = tx_cur.quick ? 0 : $urandom_range(0, MAX_GAP);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Response monitor
  int               rx_stall;
  expected_lookup_t rx_exp;
  lookup_resp_t     rx_got;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        rx_got = lookup_resp_t'(m_tdata[52:0]);
        if (expected_lookups.size() == 0) begin
          $error("response with no request pending: %h", m_tdata);
          error_count++;
          rx_stall = $urandom_range(0, MAX_GAP);
        end else begin
          rx_exp = expected_lookups.pop_front();
          if (rx_got.hit !== rx_exp.resp.hit) begin
            $error("hit: expected %0d, got %0d", rx_exp.resp.hit, rx_got.hit);
            error_count++;
          end
          if (rx_got.slot !== rx_exp.resp.slot) begin
            $error("slot: expected %0d, got %0d", rx_exp.resp.slot, rx_got.slot);
            error_count++;
          end
          if (rx_got.use_count !== rx_exp.resp.use_count) begin
            $error("use_count: expected %0d, got %0d", rx_exp.resp.use_count, rx_got.use_count);
            error_count++;
          end
          if (rx_got.evicted !== rx_exp.resp.evicted) begin
            $error("evicted: expected %0d, got %0d", rx_exp.resp.evicted, rx_got.evicted);
            error_count++;
          end
          if (rx_got.evicted_key !== rx_exp.resp.evicted_key) begin
            $error("evicted_key: expected %0d, got %0d",
                   rx_exp.resp.evicted_key, rx_got.evicted_key);
            error_count++;
          end
          rx_stall = rx_exp.quick ? 0 : $urandom_range(0, MAX_GAP);
        end
      end
      // hold the response side stalled while the drawn stall count runs down
      if (rx_stall > 0) begin
        rx_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int                 i;
    int                 pool_n;
    int                 run_n;
    int                 done_n;
    bit                 quick;
    logic signed [31:0] key;
    logic signed [31:0] pool [20];

    // fill with extreme keys and payloads
    queue_lookup(KEY_MIN, KEY_MAX, 32'sh0, -32'sd1, 1'b0, 1'b0);
    queue_lookup(KEY_MAX, KEY_MIN, -32'sd1, 32'sh0, 1'b0, 1'b0);
    queue_lookup(32'sh0, 32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa, 1'b0, 1'b0);
    queue_lookup(-32'sd1, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555, 1'b0, 1'b0);
    // hits with a new payload leave the stored one alone
    queue_lookup(KEY_MIN, 32'sh1234_5678, KEY_MAX, KEY_MIN, 1'b0, 1'b0);
    queue_lookup(KEY_MAX, -32'sd1, -32'sd1, -32'sd1, 1'b0, 1'b0);
    queue_lookup(KEY_MAX, 32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0);
    // fill the table to the last slot
    for (i = 1; i <= 4; i++) begin
      queue_lookup(i, $urandom, $urandom, $urandom, 1'b0, 1'b0);
    end
    // full table: evict on ties, then after a shift, then hit key 5 in its shifted slot
    queue_lookup(32'sd5, $urandom, $urandom, $urandom, 1'b0, 1'b0);
    queue_lookup(32'sh0, $urandom, $urandom, $urandom, 1'b0, 1'b0);
    queue_lookup(32'sd5, $urandom, $urandom, $urandom, 1'b0, 1'b0);
    // pause until everything has answered
    queue_lookup(-32'sd1, $urandom, $urandom, $urandom, 1'b1, 1'b0);

    // random runs over small key pools so hits, fills and evictions mix
    done_n = 0;
    while (done_n < RANDOM_ITEMS) begin
      pool_n = $urandom_range(3, 20);
      for (i = 0; i < pool_n; i++) begin
        case ($urandom_range(0, 7))
          0: pool[i] = KEY_MIN;
          1: pool[i] = KEY_MAX;
          2: pool[i] = $urandom_range(0, 15);
          default: pool[i] = $urandom;
        endcase
      end
      quick = ($urandom_range(0, 3) == 0);
      run_n = $urandom_range(25, 60);
      for (i = 0; i < run_n && done_n < RANDOM_ITEMS; i++) begin
        key = ($urandom_range(0, 6) == 0) ? $urandom : pool[$urandom_range(0, pool_n - 1)];
        queue_lookup(key, $urandom, $urandom, $urandom, $urandom_range(0, 59) == 0, quick);
        done_n++;
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // wait for the last response, then keep watching for stray ones
    do @(negedge clk);
    while (lookup_queue.size() > 0 || s_tvalid || expected_lookups.size() > 0);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(64'd40_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
